// ----- src/bpa_pkg.sv -----
// Shared types, constants and helper functions of the buddy page allocator.
package bpa_pkg;

    localparam int MAX_PAGES  = 16384;
    localparam int PAGE_SHIFT = 12;
    localparam int TOP_ORDER  = 10;
    localparam int ADDR_W     = 14;
    localparam int LINK_W     = 15;
    localparam int ORD_W      = 4;
    localparam int NORD       = TOP_ORDER + 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);

    // Page status codes.
    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;
    localparam logic [1:0] ST_RSVD = 2'd2;

    // Result status codes.
    localparam logic [1:0] RES_DONE   = 2'd0;
    localparam logic [1:0] RES_NOMEM  = 2'd1;
    localparam logic [1:0] RES_REJECT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TOTAL    = 2'd0;
    localparam logic [1:0] CFG_RESERVED = 2'd1;

    typedef struct packed {
        logic [1:0]        status;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_entry;

    typedef struct packed {
        logic              en_status;
        logic              en_order;
        logic              en_next;
        logic              en_prev;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

    typedef struct packed {
        logic        func;
        logic [31:0] page_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [25:0] alloc_address;
        logic [26:0] free_bytes;
    } t_result;

    // Largest aligned block order that starts at cur and ends within managed.
    function automatic logic [ORD_W-1:0] carve_order(input logic [LINK_W-1:0] cur,
                                                     input logic [LINK_W-1:0] managed);
        logic [ORD_W-1:0]  res;
        logic [LINK_W-1:0] mask;
        logic [LINK_W:0]   fin;
        res = '0;
        for (int o = 1; o <= TOP_ORDER; o++) begin
            mask = (LINK_W'(1) << o) - LINK_W'(1);
            fin  = {1'b0, cur} + ((LINK_W+1)'(1) << o);
            if ((cur & mask) == '0 && fin <= {1'b0, managed}) begin
                res = ORD_W'(o);
            end
        end
        return res;
    endfunction

    // Lowest order whose list is not empty.
    function automatic logic [ORD_W-1:0] lowest_order(input logic [NORD-1:0] busy);
        logic [ORD_W-1:0] res;
        res = '0;
        for (int o = TOP_ORDER; o >= 0; o--) begin
            if (busy[o]) begin
                res = ORD_W'(o);
            end
        end
        return res;
    endfunction

endpackage

// ----- src/bpa_page_ram.sv -----
// Page table memory: one entry per page with per-field write enables.
module bpa_page_ram
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd
);

    logic [1:0]        r_status [0:MAX_PAGES-1];
    logic [ORD_W-1:0]  r_order  [0:MAX_PAGES-1];
    logic [LINK_W-1:0] r_next   [0:MAX_PAGES-1];
    logic [LINK_W-1:0] r_prev   [0:MAX_PAGES-1];
    t_entry            r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en_status) begin
            r_status[i_wr.addr] <= i_wr.data.status;
        end
        if (i_wr.en_order) begin
            r_order[i_wr.addr] <= i_wr.data.order;
        end
        if (i_wr.en_next) begin
            r_next[i_wr.addr] <= i_wr.data.next;
        end
        if (i_wr.en_prev) begin
            r_prev[i_wr.addr] <= i_wr.data.prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.status <= r_status[i_rd_addr];
        r_rd.order  <= r_order[i_rd_addr];
        r_rd.next   <= r_next[i_rd_addr];
        r_rd.prev   <= r_prev[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

// ----- src/bpa_engine.sv -----
// Sequencer for rebuild, allocate and free over the page table memory.
module bpa_engine
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rebuild,
    input  logic [LINK_W-1:0] i_managed,
    input  logic [LINK_W-1:0] i_rsv,
    input  logic              i_start,
    input  t_req              i_req,
    output logic              o_idle,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_take
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_SWEEP    = 18'b000000000000000010,
        S_CARVE    = 18'b000000000000000100,
        S_CARVE_P  = 18'b000000000000001000,
        S_A_RD     = 18'b000000000000010000,
        S_A_UNL    = 18'b000000000000100000,
        S_A_LINK   = 18'b000000000001000000,
        S_A_SPLIT  = 18'b000000000010000000,
        S_A_SPLITP = 18'b000000000100000000,
        S_F_RD     = 18'b000000001000000000,
        S_F_CHK    = 18'b000000010000000000,
        S_F_MRD    = 18'b000000100000000000,
        S_F_MCHK   = 18'b000001000000000000,
        S_F_UNP    = 18'b000010000000000000,
        S_F_UNN    = 18'b000100000000000000,
        S_F_PUSH   = 18'b001000000000000000,
        S_F_PUSHP  = 18'b010000000000000000,
        S_DONE     = 18'b100000000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_idx, n_idx;
    logic [ORD_W-1:0]  r_ord, n_ord;
    logic [LINK_W-1:0] r_b, n_b;
    logic [LINK_W-1:0] r_h, n_h;
    logic [LINK_W-1:0] r_p, n_p;
    logic [LINK_W-1:0] r_n, n_n;
    logic [LINK_W-1:0] r_count, n_count;
    logic [LINK_W-1:0] r_head [0:TOP_ORDER];
    logic [LINK_W-1:0] n_head [0:TOP_ORDER];
    logic [1:0]        r_rstat, n_rstat;
    logic [25:0]       r_raddr, n_raddr;

    t_ram_wr           wr;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            rd;
    logic [NORD-1:0]   busy;
    logic [ORD_W-1:0]  cord, lord, k1;
    logic [LINK_W-1:0] flip, half;
    logic [19:0]       fpage;

    bpa_page_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    always_comb begin
        for (int o = 0; o <= TOP_ORDER; o++) begin
            busy[o] = (r_head[o] != NIL);
        end
    end

    assign cord  = carve_order(r_idx, i_managed);
    assign lord  = lowest_order(busy);
    assign k1    = r_ord - ORD_W'(1);
    assign half  = r_idx + (LINK_W'(1) << k1);
    assign flip  = r_idx ^ (LINK_W'(1) << r_ord);
    assign fpage = i_req.page_address[31:PAGE_SHIFT];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ord   = r_ord;
        n_b     = r_b;
        n_h     = r_h;
        n_p     = r_p;
        n_n     = r_n;
        n_count = r_count;
        n_head  = r_head;
        n_rstat = r_rstat;
        n_raddr = r_raddr;
        wr      = '0;
        rd_addr = r_idx[ADDR_W-1:0];

        unique case (r_state)
            S_SWEEP: begin
                wr.en_status = 1'b1;
                wr.en_order  = 1'b1;
                wr.en_next   = 1'b1;
                wr.en_prev   = 1'b1;
                wr.addr      = r_idx[ADDR_W-1:0];
                wr.data      = '{status: (r_idx < i_rsv) ? ST_RSVD : ST_FREE,
                                 order: '0, next: NIL, prev: NIL};
                for (int o = 0; o <= TOP_ORDER; o++) begin
                    n_head[o] = NIL;
                end
                n_count = '0;
                if (r_idx == LINK_W'(MAX_PAGES - 1)) begin
                    n_idx   = i_rsv;
                    n_state = S_CARVE;
                end else begin
                    n_idx = r_idx + LINK_W'(1);
                end
            end
            S_CARVE: begin
                if (r_idx >= i_managed) begin
                    n_state = S_IDLE;
                end else begin
                    wr.en_status = 1'b1;
                    wr.en_order  = 1'b1;
                    wr.en_next   = 1'b1;
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_idx[ADDR_W-1:0];
                    wr.data      = '{status: ST_FREE, order: cord,
                                     next: r_head[cord], prev: NIL};
                    n_h          = r_head[cord];
                    n_head[cord] = r_idx;
                    n_count      = r_count + (LINK_W'(1) << cord);
                    n_b          = r_idx;
                    n_idx        = r_idx + (LINK_W'(1) << cord);
                    n_state      = S_CARVE_P;
                end
            end
            S_CARVE_P: begin
                if (r_h != NIL) begin
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_h[ADDR_W-1:0];
                    wr.data.prev = r_b;
                end
                n_state = S_CARVE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (!i_req.func) begin
                        if (busy != '0) begin
                            n_ord   = lord;
                            n_idx   = r_head[lord];
                            n_state = S_A_RD;
                        end else begin
                            n_rstat = RES_NOMEM;
                            n_raddr = '0;
                            n_state = S_DONE;
                        end
                    end else if (i_req.page_address == '0 ||
                                 i_req.page_address[PAGE_SHIFT-1:0] != '0 ||
                                 fpage >= {5'b0, i_managed}) begin
                        n_rstat = RES_REJECT;
                        n_raddr = '0;
                        n_state = S_DONE;
                    end else begin
                        n_idx   = {1'b0, i_req.page_address[PAGE_SHIFT+ADDR_W-1:PAGE_SHIFT]};
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_UNL;
            end
            S_A_UNL: begin
                n_n           = rd.next;
                n_head[r_ord] = rd.next;
                n_count       = r_count - LINK_W'(1);
                n_state       = S_A_LINK;
            end
            S_A_LINK: begin
                if (r_n != NIL) begin
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_n[ADDR_W-1:0];
                    wr.data.prev = NIL;
                end
                n_state = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                wr.en_status = 1'b1;
                wr.en_order  = 1'b1;
                wr.en_next   = 1'b1;
                wr.en_prev   = 1'b1;
                if (r_ord == '0) begin
                    wr.addr = r_idx[ADDR_W-1:0];
                    wr.data = '{status: ST_USED, order: '0, next: NIL, prev: NIL};
                    n_rstat = RES_DONE;
                    n_raddr = {r_idx[ADDR_W-1:0], PAGE_SHIFT'(0)};
                    n_state = S_DONE;
                end else begin
                    // Push the upper half one order down.
                    wr.addr    = half[ADDR_W-1:0];
                    wr.data    = '{status: ST_FREE, order: k1, next: r_head[k1], prev: NIL};
                    n_h        = r_head[k1];
                    n_head[k1] = half;
                    n_b        = half;
                    n_ord      = k1;
                    n_state    = S_A_SPLITP;
                end
            end
            S_A_SPLITP: begin
                if (r_h != NIL) begin
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_h[ADDR_W-1:0];
                    wr.data.prev = r_b;
                end
                n_state = S_A_SPLIT;
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (rd.status != ST_USED) begin
                    n_rstat = RES_REJECT;
                    n_raddr = '0;
                    n_state = S_DONE;
                end else begin
                    wr.en_status = 1'b1;
                    wr.en_order  = 1'b1;
                    wr.addr      = r_idx[ADDR_W-1:0];
                    wr.data      = '{status: ST_FREE, order: '0, next: NIL, prev: NIL};
                    n_ord        = '0;
                    n_count      = r_count + LINK_W'(1);
                    n_state      = S_F_MRD;
                end
            end
            S_F_MRD: begin
                rd_addr = flip[ADDR_W-1:0];
                n_b     = flip;
                if (r_ord == ORD_W'(TOP_ORDER) || flip >= i_managed) begin
                    n_state = S_F_PUSH;
                end else begin
                    n_state = S_F_MCHK;
                end
            end
            S_F_MCHK: begin
                if (rd.status != ST_FREE || rd.order != r_ord) begin
                    n_state = S_F_PUSH;
                end else begin
                    n_p          = rd.prev;
                    n_n          = rd.next;
                    wr.en_order  = 1'b1;
                    wr.en_next   = 1'b1;
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_b[ADDR_W-1:0];
                    wr.data      = '{status: ST_FREE, order: '0, next: NIL, prev: NIL};
                    if (r_b < r_idx) begin
                        n_idx = r_b;
                    end
                    n_state = S_F_UNP;
                end
            end
            S_F_UNP: begin
                if (r_p != NIL) begin
                    wr.en_next   = 1'b1;
                    wr.addr      = r_p[ADDR_W-1:0];
                    wr.data.next = r_n;
                end else begin
                    n_head[r_ord] = r_n;
                end
                n_state = S_F_UNN;
            end
            S_F_UNN: begin
                if (r_n != NIL) begin
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_n[ADDR_W-1:0];
                    wr.data.prev = r_p;
                end
                n_ord   = r_ord + ORD_W'(1);
                n_state = S_F_MRD;
            end
            S_F_PUSH: begin
                wr.en_status  = 1'b1;
                wr.en_order   = 1'b1;
                wr.en_next    = 1'b1;
                wr.en_prev    = 1'b1;
                wr.addr       = r_idx[ADDR_W-1:0];
                wr.data       = '{status: ST_FREE, order: r_ord,
                                  next: r_head[r_ord], prev: NIL};
                n_h           = r_head[r_ord];
                n_head[r_ord] = r_idx;
                n_state       = S_F_PUSHP;
            end
            S_F_PUSHP: begin
                if (r_h != NIL) begin
                    wr.en_prev   = 1'b1;
                    wr.addr      = r_h[ADDR_W-1:0];
                    wr.data.prev = r_idx;
                end
                n_rstat = RES_DONE;
                n_raddr = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase

        if (i_rebuild) begin
            n_state = S_SWEEP;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_ord   <= n_ord;
        r_b     <= n_b;
        r_h     <= n_h;
        r_p     <= n_p;
        r_n     <= n_n;
        r_count <= n_count;
        r_head  <= n_head;
        r_rstat <= n_rstat;
        r_raddr <= n_raddr;
    end

    assign o_idle                = (r_state == S_IDLE);
    assign o_res_valid           = (r_state == S_DONE);
    assign o_res.status          = r_rstat;
    assign o_res.alloc_address   = r_raddr;
    assign o_res.free_bytes      = {r_count, PAGE_SHIFT'(0)};

endmodule

// ----- src/buddy_page_allocator.sv -----
// Buddy page allocator top level: handshakes, configuration and result register.
// Allocate unlinks the lowest-order free block and splits it down an order at a time;
// free merges with a free buddy an order at a time, then pushes the merged block.
// One item is worked at a time; the next is taken while a result waits in the output.
// Reset and each write to a known config register run a rebuild: a clearing pass over
// the table, then a write and a link fix per carved block; no item is taken meanwhile.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_page_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [25:0] o_alloc_address,
    output logic [26:0] o_free_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    logic [LINK_W-1:0] r_total, r_reserved;
    logic [LINK_W-1:0] managed, rsv;
    logic              cfg_wr, rebuild, idle, start, res_valid, take;
    t_req              req;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    // Always take configuration; a write to a known register restarts the rebuild.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && (i_cfg_index == CFG_TOTAL ||
                                         i_cfg_index == CFG_RESERVED);
    assign rebuild     = cfg_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= LINK_W'(MAX_PAGES);
            r_reserved <= LINK_W'(576);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_TOTAL) begin
                r_total <= i_cfg_data;
            end else begin
                r_reserved <= i_cfg_data;
            end
        end
    end

    // Clamp page count to the table and the reserved count to the page count.
    assign managed = (r_total > LINK_W'(MAX_PAGES)) ? LINK_W'(MAX_PAGES) : r_total;
    assign rsv     = (r_reserved > managed) ? managed : r_reserved;

    // Hold input off while the engine works or a configuration write arrives.
    assign o_in_ready = idle && !i_cfg_valid;
    assign start      = i_in_valid && o_in_ready;
    assign req        = '{func: i_func, page_address: i_page_address};

    bpa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rebuild   (rebuild),
        .i_managed   (managed),
        .i_rsv       (rsv),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (take)
    );

    // Advance a finished result into the output register once it is free.
    assign take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_alloc_address = r_out.alloc_address;
    assign o_free_bytes    = r_out.free_bytes;

endmodule

// ----- verif/tb_buddy_page_allocator.sv -----
// Self-checking testbench of the buddy page allocator with an in-bench page table predictor.
`timescale 1ns / 100ps

module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int          PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int          DRAIN_CYC  = 64;
    localparam int unsigned CYC_LIMIT  = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_func;
    logic [31:0] i_page_address;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [25:0] o_alloc_address;
    logic [26:0] o_free_bytes;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [14:0] i_cfg_data;

    buddy_page_allocator dut (.*);

    // Clock: 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Page table predictor: its own copy of the table, lists and registers.
    // ------------------------------------------------------------------
    logic [1:0]   pg_state [MAX_PAGES];
    logic [3:0]   pg_order [MAX_PAGES];
    int unsigned  pg_next  [MAX_PAGES];
    int unsigned  pg_prev  [MAX_PAGES];
    int unsigned  list_top [NORD];
    int unsigned  free_pages;
    int unsigned  managed_pages;
    int unsigned  reg_total;
    int unsigned  reg_rsvd;
    int unsigned  used_pages[$];   // pages the allocator has handed out

    function automatic void push_free_block(int unsigned idx, int unsigned ord);
        int unsigned h;
        h = list_top[ord];
        pg_order[idx] = 4'(ord);
        pg_state[idx] = ST_FREE;
        pg_prev[idx]  = MAX_PAGES;
        pg_next[idx]  = h;
        if (h != MAX_PAGES) pg_prev[h] = idx;
        list_top[ord] = idx;
        free_pages += 1 << ord;
    endfunction

    function automatic void unlink_free_block(int unsigned idx, int unsigned ord);
        int unsigned p;
        int unsigned n;
        p = pg_prev[idx];
        n = pg_next[idx];
        if (p != MAX_PAGES) pg_next[p] = n;
        else list_top[ord] = n;
        if (n != MAX_PAGES) pg_prev[n] = p;
        pg_next[idx] = MAX_PAGES;
        pg_prev[idx] = MAX_PAGES;
        free_pages -= 1 << ord;
    endfunction

    // Rebuild the table and carve the unreserved pages into aligned blocks.
    function automatic void carve_pages();
        int unsigned rsv;
        int unsigned cur;
        int unsigned ord;
        managed_pages = (reg_total > MAX_PAGES) ? MAX_PAGES : reg_total;
        rsv = (reg_rsvd > managed_pages) ? managed_pages : reg_rsvd;
        for (int i = 0; i < MAX_PAGES; i++) begin
            pg_state[i] = (i < rsv) ? ST_RSVD : ST_FREE;
            pg_order[i] = '0;
            pg_next[i]  = MAX_PAGES;
            pg_prev[i]  = MAX_PAGES;
        end
        for (int o = 0; o < NORD; o++) list_top[o] = MAX_PAGES;
        free_pages = 0;
        used_pages.delete();
        cur = rsv;
        while (cur < managed_pages) begin
            ord = TOP_ORDER;
            while (ord > 0 && !(((cur & ((1 << ord) - 1)) == 0) &&
                                (cur + (1 << ord) <= managed_pages)))
                ord--;
            push_free_block(cur, ord);
            cur += 1 << ord;
        end
    endfunction

    // Work out the result of one accepted item and update the table.
    function automatic t_result predict_page_op(t_req req);
        t_result     res;
        int unsigned ord;
        int unsigned base;
        int unsigned idx;
        int unsigned bud;
        bit          merging;
        res = '0;
        if (req.func == 1'b0) begin
            ord = 0;
            while (ord <= TOP_ORDER && list_top[ord] == MAX_PAGES) ord++;
            if (ord > TOP_ORDER) begin
                res.status = RES_NOMEM;
            end else begin
                base = list_top[ord];
                unlink_free_block(base, ord);
                for (int k = ord; k > 0; k--) push_free_block(base + (1 << (k - 1)), k - 1);
                pg_state[base] = ST_USED;
                pg_order[base] = '0;
                used_pages.push_back(base);
                res.status        = RES_DONE;
                res.alloc_address = 26'(base * PAGE_BYTES);
            end
        end else if (req.page_address == 0 || req.page_address[PAGE_SHIFT-1:0] != 0 ||
                     (req.page_address >> PAGE_SHIFT) >= managed_pages ||
                     pg_state[req.page_address >> PAGE_SHIFT] != ST_USED) begin
            res.status = RES_REJECT;
        end else begin
            idx = req.page_address >> PAGE_SHIFT;
            foreach (used_pages[i]) if (used_pages[i] == idx) begin
                used_pages.delete(i);
                break;
            end
            pg_state[idx] = ST_FREE;
            pg_order[idx] = '0;
            ord = 0;
            merging = 1'b1;
            while (merging && ord < TOP_ORDER) begin
                bud = idx ^ (1 << ord);
                if (bud >= managed_pages || pg_state[bud] != ST_FREE || pg_order[bud] != ord) begin
                    merging = 1'b0;
                end else begin
                    unlink_free_block(bud, ord);
                    pg_order[bud] = '0;
                    if (bud < idx) idx = bud;
                    ord++;
                end
            end
            push_free_block(idx, ord);
            res.status = RES_DONE;
        end
        res.free_bytes = 27'(free_pages * PAGE_BYTES);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue, expectations and idling control.
    // ------------------------------------------------------------------
    t_req        pending_items[$];
    t_result     expected_results[$];
    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          item_taken;

    // Sample on the rising edge: acceptances, config writes, results, watchdog.
    always @(posedge i_clk) begin
        t_result exp_res;
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        item_taken = i_rst_n && i_in_valid && o_in_ready;
        if (item_taken) begin
            expected_results.push_back(predict_page_op('{func: i_func,
                                                         page_address: i_page_address}));
            items_taken++;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TOTAL) reg_total = i_cfg_data;
            else if (i_cfg_index == CFG_RESERVED) reg_rsvd = i_cfg_data;
            carve_pages();
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %h bytes %0d",
                             o_status, o_alloc_address, o_free_bytes);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status || o_alloc_address !== exp_res.alloc_address ||
                    o_free_bytes !== exp_res.free_bytes) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0d addr %h bytes %0d, got %0d %h %0d",
                                 exp_res.status, exp_res.alloc_address, exp_res.free_bytes,
                                 o_status, o_alloc_address, o_free_bytes);
                end
            end
        end
    end

    // Drive on the falling edge: hold an item until taken, then load the next.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || item_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_func         <= pending_items[0].func;
                i_page_address <= pending_items[0].page_address;
                void'(pending_items.pop_front());
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Queue one item and wait until the block takes it, so the next pick sees fresh state.
    task automatic send_item(logic func, logic [31:0] addr);
        pending_items.push_back('{func: func, page_address: addr});
        items_queued++;
        while (items_taken != items_queued) @(posedge i_clk);
    endtask

    // Wait until every result is back and the input side is quiet.
    task automatic drain_results();
        while (expected_results.size() != 0 || i_in_valid) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [14:0] value);
        @(negedge i_clk);
        i_cfg_index = index;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random traffic: mostly allocs and frees of live pages, the rest noise.
    task automatic run_random(int unsigned count);
        int unsigned pick;
        int unsigned pg;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_item(1'b0, $urandom());
            end else if (pick < 82 && used_pages.size() > 0) begin
                pg = used_pages[$urandom_range(0, used_pages.size() - 1)];
                send_item(1'b1, pg << PAGE_SHIFT);
            end else if (pick < 90) begin
                send_item(1'b1, $urandom());
            end else if (pick < 96) begin
                pg = $urandom_range(0, managed_pages + 4);
                send_item(1'b1, pg << PAGE_SHIFT);
            end else begin
                send_item(1'b1, ($urandom_range(0, MAX_PAGES - 1) << PAGE_SHIFT) |
                                $urandom_range(1, PAGE_BYTES - 1));
            end
        end
    endtask

    task automatic run_phase(int unsigned total, int unsigned rsvd, int unsigned mode,
                             int unsigned count);
        drain_results();
        write_register(CFG_TOTAL, 15'(total));
        write_register(CFG_RESERVED, 15'(rsvd));
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        run_random(count);
    endtask

    initial begin
        logic [31:0] live_addr;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = 1'b0;
        i_page_address = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_TOTAL;
        i_cfg_data     = '0;
        items_queued   = 0;
        items_taken    = 0;
        mismatches     = 0;
        cycle_count    = 0;
        item_taken     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reg_total      = 16384;
        reg_rsvd       = 576;
        carve_pages();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset layout, every reject reason, double free, merge back.
        send_item(1'b0, '0);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, '0);
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b1, 32'h0000_0123);
        send_item(1'b1, 32'hFFFF_F000);
        send_item(1'b1, 32'h0400_0000);
        send_item(1'b1, 32'h0000_1000);
        send_item(1'b1, (MAX_PAGES - 1) << PAGE_SHIFT);
        live_addr = used_pages[0] << PAGE_SHIFT;
        send_item(1'b1, live_addr);
        send_item(1'b1, live_addr);
        while (used_pages.size() > 0) send_item(1'b1, used_pages[0] << PAGE_SHIFT);
        send_item(1'b0, '0);

        // Settings: small tables exhaust quickly, extremes of both registers.
        run_phase(64,    0,     0, 150);
        run_phase(100,   3,     1, 130);
        run_phase(16384, 16384, 2, 20);
        run_phase(32767, 5,     3, 140);
        run_phase(40,    40,    0, 20);
        run_phase(0,     0,     1, 20);
        run_phase(1000,  7,     2, 260);
        run_phase(16384, 0,     3, 150);
        run_phase(37,    1,     0, 130);
        run_phase(16384, 576,   3, 110);

        drain_results();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bpa_pkg.sv
src/bpa_page_ram.sv
src/bpa_engine.sv
src/buddy_page_allocator.sv
verif/tb_buddy_page_allocator.sv
